// ===== sv/dbpm_pkg.sv =====
// ----------------------------------------------------------------------------
// dbpm_pkg
// Shared widths, codes and types of the dot-bracket pair mapper.
// ----------------------------------------------------------------------------
package dbpm_pkg;

  localparam int MAX_SEQS_DEF    = 32;
  localparam int MAX_LEN_DEF     = 4096;
  localparam int STACK_DEPTH_DEF = 512;

  localparam int COL_W      = 32;
  localparam int KIND_W     = 2;
  localparam int POS_W      = 13;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // bracket kinds; the fourth code counts as unpaired
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OPEN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_A = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_B = 1'd1;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stk_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_stat_t;

  typedef struct packed {
    logic [POS_W-1:0]    pos_a;
    logic [POS_W-1:0]    pos_b;
    logic                aligned;
    logic                pair_a_valid;
    logic [POS_W-1:0]    pair_a_open;
    logic                pair_b_valid;
    logic [POS_W-1:0]    pair_b_open;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

// ===== sv/dbpm_stack.sv =====
// ----------------------------------------------------------------------------
// dbpm_stack
// Pairing stack: top entry in a register, the rest in a synchronous memory.
// The entry under the top is read ahead every cycle so a pop need not wait for the memory.
// ----------------------------------------------------------------------------
module dbpm_stack #(
  parameter int DEPTH = 512,
  parameter int DW    = 26
) (
  input  logic                clk,
  input  logic                rst,
  input  dbpm_pkg::stk_cmd_t  cmd,
  input  logic [DW-1:0]       push_data,
  output dbpm_pkg::stk_stat_t stat,
  output logic [DW-1:0]       top
);
  import dbpm_pkg::*;

  localparam int LVL_W = $clog2(DEPTH + 1);
  localparam int AW    = $clog2(DEPTH);

  logic [DW-1:0]    mem [DEPTH];
  logic [LVL_W-1:0] level;
  logic [LVL_W-1:0] level_next;
  logic [LVL_W-1:0] lvl_cur;
  logic [DW-1:0]    top_q;
  logic [DW-1:0]    top_next;
  logic [DW-1:0]    rd_q;
  logic [DW-1:0]    fwd_q;
  logic             fwd_sel;
  logic [DW-1:0]    under;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;

  assign lvl_cur    = cmd.clear ? '0 : level;
  assign stat.empty = (lvl_cur == '0);
  assign stat.full  = (lvl_cur == LVL_W'(DEPTH));
  assign top        = top_q;
  assign under      = fwd_sel ? fwd_q : rd_q;

  // spill the old top below the new one
  assign wr_en   = cmd.push && (lvl_cur != '0);
  assign wr_addr = AW'(lvl_cur - LVL_W'(1));

  always_comb begin
    level_next = lvl_cur;
    top_next   = top_q;
    if (cmd.push) begin
      level_next = lvl_cur + LVL_W'(1);
      top_next   = push_data;
    end else if (cmd.pop) begin
      level_next = lvl_cur - LVL_W'(1);
      top_next   = under;
    end
  end

  // prefetch the entry that sits under next cycle's top
  assign rd_addr = AW'(level_next - LVL_W'(2));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= top_q;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level   <= '0;
      fwd_sel <= 1'b0;
    end else begin
      level   <= level_next;
      fwd_sel <= wr_en;
    end
  end

  // a push reads back the entry it writes: bypass the memory
  always_ff @(posedge clk) begin
    top_q <= top_next;
    fwd_q <= top_q;
  end

endmodule

// ===== sv/dot_bracket_pair_mapper_core.sv =====
// ----------------------------------------------------------------------------
// dot_bracket_pair_mapper_core
// Maps one alignment column per request to group A/B positions and reports
// base pairs from the consensus dot-bracket line.
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//   in       in         in_valid/in_ready     column_nongap, bracket_kind, first_column
//   out      out        out_valid/out_ready   pos_a .. status
//
// One request per cycle while the skid register is empty; the result is
// registered. Pops keep this rate because the entry under the stack
// top is read ahead from the stack memory (one write, one read port).
// A skid register holds one extra result while out_ready is low; in_ready
// drops only when it is occupied. Reset clears counts, stack level and
// masks; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module dot_bracket_pair_mapper_core #(
  parameter int MAX_SEQS    = dbpm_pkg::MAX_SEQS_DEF,
  parameter int MAX_LEN     = dbpm_pkg::MAX_LEN_DEF,
  parameter int STACK_DEPTH = dbpm_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dbpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dbpm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dbpm_pkg::COL_W-1:0]      column_nongap,
  input  logic [dbpm_pkg::KIND_W-1:0]     bracket_kind,
  input  logic                            first_column,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dbpm_pkg::POS_W-1:0]      pos_a,
  output logic [dbpm_pkg::POS_W-1:0]      pos_b,
  output logic                            aligned,
  output logic                            pair_a_valid,
  output logic [dbpm_pkg::POS_W-1:0]      pair_a_open,
  output logic                            pair_b_valid,
  output logic [dbpm_pkg::POS_W-1:0]      pair_b_open,
  output logic [dbpm_pkg::STATUS_W-1:0]   status
);
  import dbpm_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int DW    = 2 * CNT_W;
  localparam logic [COL_W-1:0] SLOT_MASK =
    (MAX_SEQS >= COL_W) ? {COL_W{1'b1}} : COL_W'((64'd1 << MAX_SEQS) - 64'd1);

  logic [COL_W-1:0] group_a_mask;
  logic [COL_W-1:0] group_b_mask;
  logic [CNT_W-1:0] count_a;
  logic [CNT_W-1:0] count_b;
  logic [CNT_W-1:0] cnt_a_cur;
  logic [CNT_W-1:0] cnt_b_cur;
  logic [CNT_W-1:0] count_a_next;
  logic [CNT_W-1:0] count_b_next;
  logic [COL_W-1:0] col;
  logic             occ_a;
  logic             occ_b;
  logic             accept;

  stk_cmd_t         stk_cmd;
  stk_stat_t        stk_stat;
  logic [DW-1:0]    push_data;
  logic [DW-1:0]    stk_top;
  logic [CNT_W-1:0] top_a;
  logic [CNT_W-1:0] top_b;

  result_t          res;
  result_t          out_q;
  result_t          skid_q;
  logic             skid_valid;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_a_mask <= '0;
      group_b_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GROUP_A: group_a_mask <= cfg_data;
        CFG_GROUP_B: group_b_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // column occupancy and saturating counts
  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign col      = column_nongap & SLOT_MASK;
  assign occ_a    = |(col & group_a_mask);
  assign occ_b    = |(col & group_b_mask);

  assign cnt_a_cur = first_column ? '0 : count_a;
  assign cnt_b_cur = first_column ? '0 : count_b;

  assign count_a_next = (occ_a && cnt_a_cur < CNT_W'(MAX_LEN)) ? cnt_a_cur + CNT_W'(1)
                                                             : cnt_a_cur;
  assign count_b_next = (occ_b && cnt_b_cur < CNT_W'(MAX_LEN)) ? cnt_b_cur + CNT_W'(1)
                                                             : cnt_b_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= '0;
      count_b <= '0;
    end else if (accept) begin
      count_a <= count_a_next;
      count_b <= count_b_next;
    end
  end

  // stack commands
  assign stk_cmd.clear = accept && first_column;
  assign stk_cmd.push  = accept && (bracket_kind == KIND_OPEN) && !stk_stat.full;
  assign stk_cmd.pop   = accept && (bracket_kind == KIND_CLOSE) && !stk_stat.empty;
  assign push_data     = {occ_a ? count_a_next : CNT_W'(0),
                          occ_b ? count_b_next : CNT_W'(0)};

  dbpm_stack #(
    .DEPTH(STACK_DEPTH),
    .DW   (DW)
  ) u_stack (
    .clk      (clk),
    .rst      (rst),
    .cmd      (stk_cmd),
    .push_data(push_data),
    .stat     (stk_stat),
    .top      (stk_top)
  );

  assign top_a = stk_top[DW-1:CNT_W];
  assign top_b = stk_top[CNT_W-1:0];

  always_comb begin
    res              = '0;
    res.pos_a        = POS_W'(count_a_next);
    res.pos_b        = POS_W'(count_b_next);
    res.aligned      = occ_a && occ_b;
    res.status       = ST_OK;
    if (bracket_kind == KIND_OPEN && stk_stat.full) begin
      res.status = ST_OVERFLOW;
    end else if (bracket_kind == KIND_CLOSE) begin
      if (stk_stat.empty) begin
        res.status = ST_EMPTY;
      end else begin
        res.pair_a_valid = (top_a != '0);
        res.pair_a_open  = POS_W'(top_a);
        res.pair_b_valid = (top_b != '0);
        res.pair_b_open  = POS_W'(top_b);
      end
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_q <= skid_valid ? skid_q : res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign pos_a        = out_q.pos_a;
  assign pos_b        = out_q.pos_b;
  assign aligned      = out_q.aligned;
  assign pair_a_valid = out_q.pair_a_valid;
  assign pair_a_open  = out_q.pair_a_open;
  assign pair_b_valid = out_q.pair_b_valid;
  assign pair_b_open  = out_q.pair_b_open;
  assign status       = out_q.status;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dot_bracket_pair_mapper_core. A short table of
// columns probes reset state, an empty stack and the spare
// bracket code. A run with full masks fills the pairing stack past its depth
// and drains it past empty. Random bracket structures then run under four
// idle and stall mixes, and a local predictor checks every result field by
// field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dbpm_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int ITEMS_PER_HALF  = 64;
  localparam int LONG_PLAIN      = 48;
  localparam int LONG_BRACKETS   = 520;
  localparam int MASK_SETTINGS   = 8;

  typedef struct packed {
    logic [POS_W-1:0] a;
    logic [POS_W-1:0] b;
  } open_entry_t;

  typedef struct {
    logic [COL_W-1:0]  col;
    logic [KIND_W-1:0] kind;
    logic              first;
    bit                typed;
    result_t           want;
  } column_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_GROUP_A;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [COL_W-1:0]      column_nongap = '0;
  logic [KIND_W-1:0]     bracket_kind = KIND_NONE;
  logic                  first_column = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [POS_W-1:0]      pos_a;
  logic [POS_W-1:0]      pos_b;
  logic                  aligned;
  logic                  pair_a_valid;
  logic [POS_W-1:0]      pair_a_open;
  logic                  pair_b_valid;
  logic [POS_W-1:0]      pair_b_open;
  logic [STATUS_W-1:0]   status;

  dot_bracket_pair_mapper_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .column_nongap(column_nongap),
    .bracket_kind (bracket_kind),
    .first_column (first_column),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pos_a        (pos_a),
    .pos_b        (pos_b),
    .aligned      (aligned),
    .pair_a_valid (pair_a_valid),
    .pair_a_open  (pair_a_open),
    .pair_b_valid (pair_b_valid),
    .pair_b_open  (pair_b_open),
    .status       (status)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [CFG_DATA_W-1:0] group_a_sel;
  logic [CFG_DATA_W-1:0] group_b_sel;
  logic [POS_W-1:0]      residues_a;
  logic [POS_W-1:0]      residues_b;
  open_entry_t           open_stack [STACK_DEPTH_DEF];
  logic [9:0]            open_depth;

  result_t     pending_results [$];
  column_row_t directed_rows [$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int errors             = 0;
  int columns_sent       = 0;
  int results_checked    = 0;
  int structures_sent    = 0;
  int overflows_seen     = 0;
  int empty_pops_seen    = 0;
  int cycle_count        = 0;

  function automatic result_t map_column(input logic [COL_W-1:0] col,
                                         input logic [KIND_W-1:0] kind,
                                         input logic first);
    result_t     r;
    logic        occ_a;
    logic        occ_b;
    open_entry_t top;
    r = '0;
    if (first) begin
      residues_a = '0;
      residues_b = '0;
      open_depth = '0;
    end
    occ_a = |(col & group_a_sel);
    occ_b = |(col & group_b_sel);
    if (occ_a && residues_a < MAX_LEN_DEF) residues_a = residues_a + POS_W'(1);
    if (occ_b && residues_b < MAX_LEN_DEF) residues_b = residues_b + POS_W'(1);
    if (kind == KIND_OPEN) begin
      if (open_depth >= STACK_DEPTH_DEF) begin
        r.status = ST_OVERFLOW;
      end else begin
        open_stack[open_depth[8:0]].a = occ_a ? residues_a : '0;
        open_stack[open_depth[8:0]].b = occ_b ? residues_b : '0;
        open_depth = open_depth + 10'd1;
      end
    end else if (kind == KIND_CLOSE) begin
      if (open_depth == 0) begin
        r.status = ST_EMPTY;
      end else begin
        open_depth = open_depth - 10'd1;
        top = open_stack[open_depth[8:0]];
        r.pair_a_valid = (top.a != 0);
        r.pair_a_open  = top.a;
        r.pair_b_valid = (top.b != 0);
        r.pair_b_open  = top.b;
      end
    end
    r.pos_a   = residues_a;
    r.pos_b   = residues_b;
    r.aligned = occ_a && occ_b;
    return r;
  endfunction

  function automatic result_t make_result(input int pa, input int pb, input int al,
                                          input int va, input int oa, input int vb,
                                          input int ob, input logic [STATUS_W-1:0] st);
    result_t r;
    r.pos_a        = pa[POS_W-1:0];
    r.pos_b        = pb[POS_W-1:0];
    r.aligned      = al[0];
    r.pair_a_valid = va[0];
    r.pair_a_open  = oa[POS_W-1:0];
    r.pair_b_valid = vb[0];
    r.pair_b_open  = ob[POS_W-1:0];
    r.status       = st;
    return r;
  endfunction

  function automatic void add_row(input logic [COL_W-1:0] col, input logic [KIND_W-1:0] kind,
                                  input logic first, input bit typed, input result_t want);
    column_row_t row;
    row.col   = col;
    row.kind  = kind;
    row.first = first;
    row.typed = typed;
    row.want  = want;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic logic [COL_W-1:0] random_column();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom & $urandom & $urandom;
      2:       return $urandom & $urandom & $urandom & $urandom & $urandom;
      default: return '0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                results_checked, name, got, want));
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with no request outstanding");
      return;
    end
    want = pending_results.pop_front();
    check_field("pos_a", 32'(pos_a), 32'(want.pos_a));
    check_field("pos_b", 32'(pos_b), 32'(want.pos_b));
    check_field("aligned", 32'(aligned), 32'(want.aligned));
    check_field("pair_a_valid", 32'(pair_a_valid), 32'(want.pair_a_valid));
    check_field("pair_a_open", 32'(pair_a_open), 32'(want.pair_a_open));
    check_field("pair_b_valid", 32'(pair_b_valid), 32'(want.pair_b_valid));
    check_field("pair_b_open", 32'(pair_b_open), 32'(want.pair_b_open));
    check_field("status", 32'(status), 32'(want.status));
    if (want.status == ST_OVERFLOW) overflows_seen++;
    if (want.status == ST_EMPTY) empty_pops_seen++;
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_column(input logic [COL_W-1:0] col, input logic [KIND_W-1:0] kind,
                             input logic first, input bit typed, input result_t want);
    result_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    column_nongap <= col;
    bracket_kind  <= kind;
    first_column  <= first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = map_column(col, kind, first);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
    columns_sent++;
  endtask

  task automatic send_plain(input logic [COL_W-1:0] col, input logic [KIND_W-1:0] kind,
                            input logic first);
    send_column(col, kind, first, 1'b0, '0);
  endtask

  // hold until every result is out, then give the block time to go quiet
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_GROUP_A) group_a_sel = data;
    else group_b_sel = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one well-formed bracket structure; sometimes one position gets a random kind
  task automatic send_structure();
    int                len;
    int                depth;
    int                remaining;
    int                roll;
    int                break_at;
    logic [KIND_W-1:0] kind;
    len      = $urandom_range(2, 40);
    break_at = ($urandom_range(9) == 0) ? $urandom_range(len - 1) : -1;
    depth    = 0;
    for (int i = 0; i < len; i++) begin
      remaining = len - i;
      roll      = $urandom_range(99);
      if (depth >= remaining) kind = KIND_CLOSE;
      else if (roll < 35 && depth + 1 < remaining) kind = KIND_OPEN;
      else if (roll < 70 && depth > 0) kind = KIND_CLOSE;
      else kind = KIND_NONE;
      if (i == break_at) kind = KIND_W'($urandom_range(3));
      if (kind == KIND_OPEN) depth++;
      if (kind == KIND_CLOSE && depth > 0) depth--;
      send_plain(random_column(), kind, i == 0);
    end
    structures_sent++;
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] mask_a_set [MASK_SETTINGS];
    logic [CFG_DATA_W-1:0] mask_b_set [MASK_SETTINGS];
    int                    idle_set   [4];
    int                    stall_set  [4];
    int                    start_count;
    int                    setting;

    group_a_sel = '0;
    group_b_sel = '0;
    residues_a  = '0;
    residues_b  = '0;
    open_depth  = '0;

    // masks are clear after reset
    add_row(32'hFFFF_FFFF, KIND_CLOSE, 1'b1, 1'b1, make_result(0, 0, 0, 0, 0, 0, 0, ST_EMPTY));
    add_row(32'hFFFF_FFFF, KIND_OPEN,  1'b0, 1'b1, make_result(0, 0, 0, 0, 0, 0, 0, ST_OK));
    add_row(32'h0000_0000, KIND_CLOSE, 1'b0, 1'b1, make_result(0, 0, 0, 0, 0, 0, 0, ST_OK));
    add_row(32'hFFFF_FFFF, KIND_SPARE, 1'b0, 1'b1, make_result(0, 0, 0, 0, 0, 0, 0, ST_OK));
    // A on the low half, B on the high half
    add_row(32'h0000_0001, KIND_OPEN,  1'b1, 1'b1, make_result(1, 0, 0, 0, 0, 0, 0, ST_OK));
    add_row(32'h0001_0001, KIND_OPEN,  1'b0, 1'b1, make_result(2, 1, 1, 0, 0, 0, 0, ST_OK));
    add_row(32'h0001_0000, KIND_NONE,  1'b0, 1'b0, '0);
    add_row(32'hFFFF_FFFF, KIND_CLOSE, 1'b0, 1'b0, '0);
    add_row(32'h0000_0000, KIND_CLOSE, 1'b0, 1'b0, '0);
    add_row(32'h0000_0000, KIND_CLOSE, 1'b0, 1'b0, '0);
    add_row(32'h8000_0000, KIND_SPARE, 1'b0, 1'b0, '0);
    add_row(32'hFFFF_0000, KIND_OPEN,  1'b1, 1'b1, make_result(0, 1, 0, 0, 0, 0, 0, ST_OK));
    add_row(32'h0000_FFFF, KIND_CLOSE, 1'b0, 1'b0, '0);
    add_row(32'h8000_8000, KIND_OPEN,  1'b0, 1'b0, '0);
    add_row(32'h0000_0000, KIND_CLOSE, 1'b0, 1'b0, '0);
    add_row(32'hFFFF_FFFF, KIND_NONE,  1'b1, 1'b1, make_result(1, 1, 1, 0, 0, 0, 0, ST_OK));

    mask_a_set = '{32'hFFFF_FFFF, $urandom, 32'h0, $urandom,
                   32'h0000_0001, $urandom & $urandom, 32'hFFFF_FFFF, $urandom};
    mask_b_set = '{32'hFFFF_FFFF, $urandom, $urandom, 32'h0,
                   32'h8000_0000, $urandom, 32'h0, 32'hFFFF_FFFF};
    idle_set   = '{0, 76, 0, 30};
    stall_set  = '{0, 0, 76, 30};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < directed_rows.size(); i++) begin
      if (i == 4) begin
        settle_block();
        write_mask(CFG_GROUP_A, 32'h0000_FFFF);
        write_mask(CFG_GROUP_B, 32'hFFFF_0000);
      end
      send_column(directed_rows[i].col, directed_rows[i].kind, directed_rows[i].first,
                  directed_rows[i].typed, directed_rows[i].want);
    end

    // every plain and opening column occupies both groups: the stack fills past its depth,
    // then drains past empty
    settle_block();
    write_mask(CFG_GROUP_A, 32'hFFFF_FFFF);
    write_mask(CFG_GROUP_B, 32'hFFFF_FFFF);
    send_plain($urandom | 32'h1, KIND_NONE, 1'b1);
    for (int i = 1; i < LONG_PLAIN; i++) send_plain($urandom | 32'h1, KIND_NONE, 1'b0);
    for (int i = 0; i < LONG_BRACKETS; i++) send_plain($urandom | 32'h1, KIND_OPEN, 1'b0);
    for (int i = 0; i < LONG_BRACKETS; i++) send_plain($urandom, KIND_CLOSE, 1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      for (int half = 0; half < 2; half++) begin
        settle_block();
        setting            = 2 * phase + half;
        sender_idle_pct    = idle_set[phase];
        receiver_stall_pct = stall_set[phase];
        write_mask(CFG_GROUP_A, mask_a_set[setting]);
        write_mask(CFG_GROUP_B, mask_b_set[setting]);
        start_count = columns_sent;
        while (columns_sent - start_count < ITEMS_PER_HALF) begin
          if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 5))
              send_plain($urandom, KIND_W'($urandom_range(3)), $urandom_range(7) == 0);
          end else begin
            send_structure();
          end
        end
      end
    end

    settle_block();
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("%0d columns sent, %0d results checked, %0d bracket structures, %0d errors",
             columns_sent, results_checked, structures_sent, errors);
    $display("%0d mask settings over four idle/stall mixes; %0d overflows, %0d empty pops",
             MASK_SETTINGS + 3, overflows_seen, empty_pops_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
